// File: rtl/y86_pkg.sv
// Package with opcodes, status codes, sequencer states and sizes of the Y86 execute unit.
package y86_pkg;

  localparam int unsigned MemBytes  = 1024;
  localparam int unsigned MemAw     = $clog2(MemBytes);
  localparam int unsigned WinW      = 11;
  localparam logic [3:0]  StackReg  = 4'h4;
  localparam logic [3:0]  BadReg    = 4'hf;

  typedef enum logic [4:0] {
    CMD_NOP = 5'd0, CMD_HALT = 5'd1, CMD_RRMOV = 5'd2, CMD_IRMOV = 5'd3,
    CMD_RMMOV = 5'd4, CMD_MRMOV = 5'd5, CMD_PUSH = 5'd6, CMD_POP = 5'd7,
    CMD_CALL = 5'd8, CMD_RET = 5'd9, CMD_JMP = 5'd10, CMD_JE = 5'd11,
    CMD_JNE = 5'd12, CMD_JL = 5'd13, CMD_JLE = 5'd14, CMD_JG = 5'd15,
    CMD_JGE = 5'd16, CMD_ADD = 5'd17, CMD_SUB = 5'd18, CMD_MUL = 5'd19,
    CMD_MOD = 5'd20, CMD_DIV = 5'd21, CMD_AND = 5'd22, CMD_XOR = 5'd23,
    CMD_CMOVE = 5'd24, CMD_CMOVNE = 5'd25, CMD_CMOVL = 5'd26, CMD_CMOVLE = 5'd27,
    CMD_CMOVG = 5'd28, CMD_CMOVGE = 5'd29, CMD_BAD0 = 5'd30, CMD_BAD1 = 5'd31
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ERR = 2'd1, ST_HALT = 2'd2, ST_RSVD = 2'd3
  } status_e;

  localparam logic [0:0] CfgBase  = 1'b0;
  localparam logic [0:0] CfgValid = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_MUL, S_DIV, S_DIVFIX, S_MEMRD, S_MEMWR, S_WB, S_OUT
  } state_e;

  // Condition test on flags {sign, zero}: 0 e, 1 ne, 2 l, 3 le, 4 g, 5 ge.
  function automatic logic cond_holds(logic [2:0] which, logic [1:0] fl);
    logic z;
    logic s;
    z = fl[0];
    s = fl[1];
    unique case (which)
      3'd0:    cond_holds = z;
      3'd1:    cond_holds = !z;
      3'd2:    cond_holds = s;
      3'd3:    cond_holds = s | z;
      3'd4:    cond_holds = !s & !z;
      default: cond_holds = !s;
    endcase
  endfunction

endpackage

// File: rtl/y86_instruction_execute_unit.sv
// Top level of the Y86 execute unit: register file, flags, pc, memory and sequencer.
//
// The unit takes one decoded instruction per request on the slave stream and
// returns one result on the master stream. Work is sequential: an instruction
// is not accepted while the previous one is in flight or its result waits.
// One shared 64-bit adder/subtractor serves address, stack and ALU arithmetic;
// multiply accumulates 16x64 partial products, 16 bits of the multiplier at a
// time, and divide/modulo runs a restoring divider one quotient bit per cycle.
// Memory is a byte-wide RAM accessed one byte per cycle, so a quadword load or
// store walks its eight bytes in turn. After each taken result the unit returns
// to idle before it accepts the next request. After reset a clearing pass
// writes zero to all 1024 memory bytes, one per cycle, and the first request
// is accepted only after that pass.
module y86_instruction_execute_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: command[4:0], reg_a[8:5], reg_b[12:9], immediate[76:13], zero fill
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[1:0], program_counter_out[65:2], flags_out[67:66], zero fill
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned Aw = y86_pkg::MemAw;

  // Configuration registers.
  logic [63:0]             base_q;
  logic [y86_pkg::WinW-1:0] vbytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      vbytes_q <= y86_pkg::WinW'(1024);
    end else if (cfg_we_i) begin
      if (cfg_index_i == y86_pkg::CfgBase) base_q <= cfg_wdata_i;
      else vbytes_q <= cfg_wdata_i[y86_pkg::WinW-1:0];
    end
  end

  // Architectural state.
  logic [63:0] rf_q [16];
  logic [63:0] pc_q, pc_d;
  logic [1:0]  fl_q, fl_d;

  // Byte memory, zeroed by the clearing pass after reset.
  logic [7:0]          mem [y86_pkg::MemBytes];
  logic                mem_we;
  logic [Aw-1:0]       mem_addr;
  logic [7:0]          mem_wdata, mem_rdata_q;
  logic [Aw-1:0]       clr_q, clr_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_q <= mem[mem_addr];
  end

  // Sequencer registers.
  y86_pkg::state_e state_q, state_d;
  y86_pkg::cmd_e   cmd_q, cmd_d;
  logic [3:0]  ra_q, ra_d, rb_q, rb_d;
  logic [63:0] imm_q, imm_d;
  logic [63:0] va_q, va_d, vb_q, vb_d;
  logic [63:0] acc_q, acc_d;      // result / quad being assembled
  logic [63:0] quo_q, quo_d;      // divider quotient, also multiplier operand
  logic [63:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [Aw-1:0] off_q, off_d;
  logic [1:0]  st_q, st_d;
  logic        neg_q, neg_d, rneg_q, rneg_d;

  // Write-back request to the register file (up to two writes).
  logic        wa_en, wb_en;
  logic [3:0]  wa_idx, wb_idx;
  logic [63:0] wa_val, wb_val;

  // Shared adder.
  logic [63:0] add_x, add_y;
  logic        add_sub;
  logic [64:0] add_r;
  assign add_r = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + 65'(add_sub);

  // Window check of a 64-bit address (uses its own subtract and compare).
  function automatic logic win_ok(logic [63:0] a, logic [63:0] b,
                                  logic [y86_pkg::WinW-1:0] vb);
    logic [63:0] d;
    logic [y86_pkg::WinW-1:0] w;
    d = a - b;
    w = (vb < y86_pkg::WinW'(y86_pkg::MemBytes)) ? vb : y86_pkg::WinW'(y86_pkg::MemBytes);
    win_ok = (a >= b) && (w >= y86_pkg::WinW'(8)) && (d <= 64'(w - y86_pkg::WinW'(8)));
  endfunction

  logic [4:0]  in_cmd;
  logic [3:0]  in_ra, in_rb;
  assign in_cmd = s_axis_tdata[4:0];
  assign in_ra  = s_axis_tdata[8:5];
  assign in_rb  = s_axis_tdata[12:9];

  assign s_axis_tready = (state_q == y86_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == y86_pkg::S_OUT);
  assign m_axis_tdata  = {4'b0, fl_q, pc_q, st_q};

  logic bad_a, bad_b;
  assign bad_a = (ra_q == y86_pkg::BadReg);
  assign bad_b = (rb_q == y86_pkg::BadReg);

  // 64x16 partial product; only its low 64 bits can reach the result.
  logic [79:0] mul_full;
  logic [63:0] mul_pp;
  assign mul_full = {16'b0, vb_q} * {64'b0, quo_q[15:0]};
  assign mul_pp   = mul_full[63:0];

  logic [64:0] div_trial;
  assign div_trial = {rem_q, quo_q[63]} - {1'b0, va_q};

  always_comb begin
    state_d = state_q; cmd_d = cmd_q; ra_d = ra_q; rb_d = rb_q; imm_d = imm_q;
    va_d = va_q; vb_d = vb_q; acc_d = acc_q; quo_d = quo_q; rem_d = rem_q;
    cnt_d = cnt_q; off_d = off_q; st_d = st_q; neg_d = neg_q; rneg_d = rneg_q;
    pc_d = pc_q; fl_d = fl_q; clr_d = clr_q;
    wa_en = 1'b0; wb_en = 1'b0; wa_idx = ra_q; wb_idx = rb_q;
    wa_val = acc_q; wb_val = acc_q;
    add_x = pc_q; add_y = 64'd0; add_sub = 1'b0;
    mem_we = 1'b0; mem_addr = off_q + Aw'(cnt_q[2:0]); mem_wdata = acc_q[7:0];

    unique case (state_q)
      y86_pkg::S_CLEAR: begin
        // Zero one memory byte per cycle after reset.
        mem_we = 1'b1; mem_addr = clr_q; mem_wdata = 8'h00;
        clr_d = clr_q + Aw'(1);
        if (clr_q == Aw'(y86_pkg::MemBytes - 1)) state_d = y86_pkg::S_IDLE;
      end
      y86_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = y86_pkg::cmd_e'(in_cmd);
          ra_d  = in_ra; rb_d = in_rb;
          imm_d = s_axis_tdata[76:13];
          va_d  = rf_q[in_ra];
          vb_d  = rf_q[in_rb];
          state_d = y86_pkg::S_DECODE;
        end
      end
      y86_pkg::S_DECODE: begin
        st_d = y86_pkg::ST_OK; cnt_d = '0; state_d = y86_pkg::S_OUT;
        priority case (cmd_q)
          y86_pkg::CMD_NOP:  begin add_y = 64'd1; pc_d = add_r[63:0]; end
          y86_pkg::CMD_HALT: st_d = y86_pkg::ST_HALT;
          y86_pkg::CMD_RRMOV: begin
            if (bad_a || bad_b) st_d = y86_pkg::ST_ERR;
            else begin
              wb_en = 1'b1; wb_val = va_q; add_y = 64'd2; pc_d = add_r[63:0];
            end
          end
          y86_pkg::CMD_IRMOV: begin
            if (bad_b) st_d = y86_pkg::ST_ERR;
            else begin
              wb_en = 1'b1; wb_val = imm_q; add_y = 64'd10; pc_d = add_r[63:0];
            end
          end
          y86_pkg::CMD_RMMOV, y86_pkg::CMD_MRMOV: begin
            add_x = vb_q; add_y = imm_q;
            if (bad_a || bad_b || !win_ok(add_r[63:0], base_q, vbytes_q)) st_d = y86_pkg::ST_ERR;
            else begin
              off_d = Aw'(add_r[63:0] - base_q);
              acc_d = va_q;
              state_d = (cmd_q == y86_pkg::CMD_RMMOV) ? y86_pkg::S_MEMWR : y86_pkg::S_MEMRD;
            end
          end
          y86_pkg::CMD_PUSH, y86_pkg::CMD_CALL: begin
            add_x = rf_q[y86_pkg::StackReg]; add_y = 64'd8; add_sub = 1'b1;
            if ((cmd_q == y86_pkg::CMD_PUSH && (bad_a || add_x < 64'd8)) ||
                (cmd_q == y86_pkg::CMD_CALL && add_x == 64'd0) ||
                !win_ok(add_r[63:0], base_q, vbytes_q)) st_d = y86_pkg::ST_ERR;
            else begin
              off_d = Aw'(add_r[63:0] - base_q);
              acc_d = (cmd_q == y86_pkg::CMD_PUSH) ? va_q : pc_q + 64'd9;
              quo_d = add_r[63:0];
              state_d = y86_pkg::S_MEMWR;
            end
          end
          y86_pkg::CMD_POP, y86_pkg::CMD_RET: begin
            add_x = rf_q[y86_pkg::StackReg]; add_y = 64'd8;
            if ((cmd_q == y86_pkg::CMD_POP && bad_a) ||
                !win_ok(add_x, base_q, vbytes_q)) st_d = y86_pkg::ST_ERR;
            else begin
              off_d = Aw'(add_x - base_q);
              quo_d = add_r[63:0];
              acc_d = '0;
              state_d = y86_pkg::S_MEMRD;
            end
          end
          y86_pkg::CMD_JMP: pc_d = imm_q;
          y86_pkg::CMD_JE, y86_pkg::CMD_JNE, y86_pkg::CMD_JL, y86_pkg::CMD_JLE,
          y86_pkg::CMD_JG, y86_pkg::CMD_JGE: begin
            add_y = 64'd9;
            pc_d = y86_pkg::cond_holds(3'(cmd_q - y86_pkg::CMD_JE), fl_q) ?
                   imm_q : add_r[63:0];
          end
          y86_pkg::CMD_CMOVE, y86_pkg::CMD_CMOVNE, y86_pkg::CMD_CMOVL,
          y86_pkg::CMD_CMOVLE, y86_pkg::CMD_CMOVG, y86_pkg::CMD_CMOVGE: begin
            if (bad_a || bad_b) st_d = y86_pkg::ST_ERR;
            else begin
              wb_en = y86_pkg::cond_holds(3'(cmd_q - y86_pkg::CMD_CMOVE), fl_q);
              wb_val = va_q; add_y = 64'd2; pc_d = add_r[63:0];
            end
          end
          y86_pkg::CMD_ADD, y86_pkg::CMD_SUB, y86_pkg::CMD_AND, y86_pkg::CMD_XOR: begin
            if (bad_a || bad_b) st_d = y86_pkg::ST_ERR;
            else begin
              add_x = vb_q; add_y = va_q; add_sub = (cmd_q == y86_pkg::CMD_SUB);
              if (cmd_q == y86_pkg::CMD_AND) acc_d = vb_q & va_q;
              else if (cmd_q == y86_pkg::CMD_XOR) acc_d = vb_q ^ va_q;
              else acc_d = add_r[63:0];
              state_d = y86_pkg::S_WB;
            end
          end
          y86_pkg::CMD_MUL: begin
            if (bad_a || bad_b) st_d = y86_pkg::ST_ERR;
            else begin
              quo_d = va_q; acc_d = '0; state_d = y86_pkg::S_MUL;
            end
          end
          y86_pkg::CMD_MOD, y86_pkg::CMD_DIV: begin
            if (bad_a || bad_b) st_d = y86_pkg::ST_ERR;
            else if (va_q == 64'd0) begin
              if (cmd_q == y86_pkg::CMD_DIV) st_d = y86_pkg::ST_ERR;
              else if (vb_q == 64'd0) begin
                st_d = y86_pkg::ST_ERR; fl_d = 2'b01;
              end else begin
                add_y = 64'd2; pc_d = add_r[63:0];
              end
            end else begin
              neg_d  = vb_q[63] ^ va_q[63];
              rneg_d = vb_q[63];
              quo_d  = vb_q[63] ? (64'd0 - vb_q) : vb_q;
              va_d   = va_q[63] ? (64'd0 - va_q) : va_q;
              rem_d  = '0;
              state_d = y86_pkg::S_DIV;
            end
          end
          default: st_d = y86_pkg::ST_ERR;
        endcase
      end
      y86_pkg::S_MUL: begin
        // Partial product of vb by 16 bits of va, shifted into place.
        acc_d = acc_q + (mul_pp << {cnt_q[1:0], 4'b0});
        quo_d = {16'b0, quo_q[63:16]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) state_d = y86_pkg::S_WB;
      end
      y86_pkg::S_DIV: begin
        if (!div_trial[64]) rem_d = div_trial[63:0];
        else rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], !div_trial[64]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) state_d = y86_pkg::S_DIVFIX;
      end
      y86_pkg::S_DIVFIX: begin
        add_x = 64'd0; add_sub = 1'b1;
        if (cmd_q == y86_pkg::CMD_DIV) begin
          add_y = quo_q; acc_d = neg_q ? add_r[63:0] : quo_q;
        end else begin
          add_y = rem_q; acc_d = rneg_q ? add_r[63:0] : rem_q;
        end
        state_d = y86_pkg::S_WB;
      end
      y86_pkg::S_WB: begin
        wb_en = 1'b1; wb_val = acc_q;
        fl_d = {acc_q[63], acc_q == 64'd0};
        add_y = 64'd2; pc_d = add_r[63:0];
        state_d = y86_pkg::S_OUT;
      end
      y86_pkg::S_MEMWR: begin
        // One byte per cycle, low byte first.
        mem_we = 1'b1; mem_wdata = acc_q[7:0];
        acc_d = {8'b0, acc_q[63:8]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[2:0] == 3'd7) begin
          state_d = y86_pkg::S_OUT;
          wb_en = 1'b1; wb_idx = y86_pkg::StackReg; wb_val = quo_q;
          if (cmd_q == y86_pkg::CMD_RMMOV) begin
            wb_en = 1'b0; add_y = 64'd10; pc_d = add_r[63:0];
          end else if (cmd_q == y86_pkg::CMD_PUSH) begin
            add_y = 64'd2; pc_d = add_r[63:0];
          end else pc_d = imm_q;
        end
      end
      y86_pkg::S_MEMRD: begin
        // The registered read data lags its address; cnt runs 0..8.
        mem_addr = off_q + Aw'(cnt_q[2:0]);
        if (cnt_q != 7'd0)
          acc_d = {mem_rdata_q, acc_q[63:8]};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          state_d = y86_pkg::S_OUT;
          unique case (cmd_q)
            y86_pkg::CMD_MRMOV: begin
              wa_en = 1'b1; wa_val = acc_d; add_y = 64'd10; pc_d = add_r[63:0];
            end
            y86_pkg::CMD_POP: begin
              wb_en = 1'b1; wb_idx = y86_pkg::StackReg; wb_val = quo_q;
              wa_en = 1'b1; wa_val = acc_d; add_y = 64'd2; pc_d = add_r[63:0];
            end
            default: begin
              wb_en = 1'b1; wb_idx = y86_pkg::StackReg; wb_val = quo_q; pc_d = acc_d;
            end
          endcase
        end
      end
      y86_pkg::S_OUT: begin
        if (m_axis_tready) state_d = y86_pkg::S_IDLE;
      end
      default: state_d = y86_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= y86_pkg::S_CLEAR;
      pc_q    <= '0;
      fl_q    <= '0;
      st_q    <= y86_pkg::ST_OK;
      cnt_q   <= '0;
      clr_q   <= '0;
      for (int i = 0; i < 16; i++) rf_q[i] <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      fl_q    <= fl_d;
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      // The first write port wins, so popq into the stack register keeps the load.
      for (int i = 0; i < 16; i++) begin
        if (wa_en && wa_idx == 4'(i)) rf_q[i] <= wa_val;
        else if (wb_en && wb_idx == 4'(i)) rf_q[i] <= wb_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ra_q <= ra_d; rb_q <= rb_d; imm_q <= imm_d;
    va_q <= va_d; vb_q <= vb_d; acc_q <= acc_d; quo_q <= quo_d; rem_q <= rem_d;
    off_q <= off_d; neg_q <= neg_d; rneg_q <= rneg_d;
  end

  // An input request is only taken while no result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // A result held under back-pressure keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A divide runs exactly 64 steps before its fix-up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == y86_pkg::S_DIVFIX |-> $past(cnt_q) == 7'd63)
    else $error("divider step count wrong");

endmodule

// File: tb/sv/y86_result_checker.sv
// Checker for the Y86 execute unit: predicts each instruction's result and compares it.
`timescale 1ns / 100ps
module y86_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  localparam int unsigned ExpDepth = 16;

  logic [63:0] regs[16];
  logic [63:0] pc_q;
  logic [1:0]  flags_q;
  logic [7:0]  mem[y86_pkg::MemBytes];
  logic [63:0] base_q;
  logic [10:0] valid_q;
  // Ring of predicted results, written at exp_wr and read at exp_rd.
  logic [71:0] expected_results[ExpDepth];
  int          exp_wr;
  int          exp_rd;

  function automatic logic test_cond(logic [2:0] which);
    logic z, s;
    z = flags_q[0];
    s = flags_q[1];
    case (which)
      3'd0: return z;
      3'd1: return !z;
      3'd2: return s;
      3'd3: return s | z;
      3'd4: return !s & !z;
      default: return !s;
    endcase
  endfunction

  function automatic logic window_hit(logic [63:0] addr, output int offset);
    logic [63:0] win, d;
    win = (valid_q < y86_pkg::MemBytes) ? 64'(valid_q) : 64'(y86_pkg::MemBytes);
    offset = 0;
    if (addr < base_q || win < 8) return 1'b0;
    d = addr - base_q;
    if (d > win - 8) return 1'b0;
    offset = int'(d);
    return 1'b1;
  endfunction

  function automatic logic [63:0] load_quad(int offset);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = mem[offset + i];
    return v;
  endfunction

  task automatic store_quad(int offset, logic [63:0] v);
    for (int i = 0; i < 8; i++) mem[offset + i] = v[8*i +: 8];
  endtask

  task automatic set_flags(logic [63:0] v);
    flags_q = {v[63], v == 64'd0};
  endtask

  // Signed divide truncating toward zero; the remainder follows the dividend.
  function automatic void divmod(logic [63:0] b, logic [63:0] a,
                                 output logic [63:0] q, output logic [63:0] r);
    logic [63:0] mb, ma, uq, ur;
    mb = b[63] ? -b : b;
    ma = a[63] ? -a : a;
    uq = mb / ma;
    ur = mb % ma;
    q = (b[63] != a[63]) ? -uq : uq;
    r = b[63] ? -ur : ur;
  endfunction

  task automatic execute_instruction(logic [79:0] word);
    y86_pkg::cmd_e    cmd;
    logic [3:0]       ra, rb;
    logic [63:0]      imm, npc, rsp, va, vb, t, q, r;
    logic             bad_a, bad_b;
    int               offset;
    y86_pkg::status_e st;
    cmd = y86_pkg::cmd_e'(word[4:0]);
    ra = word[8:5];
    rb = word[12:9];
    imm = word[76:13];
    bad_a = ra == y86_pkg::BadReg;
    bad_b = rb == y86_pkg::BadReg;
    npc = pc_q;
    rsp = regs[y86_pkg::StackReg];
    st = y86_pkg::ST_OK;
    if (cmd >= y86_pkg::CMD_JE && cmd <= y86_pkg::CMD_JGE) begin
      npc = test_cond(3'(cmd - y86_pkg::CMD_JE)) ? imm : pc_q + 9;
    end else if (cmd >= y86_pkg::CMD_CMOVE && cmd <= y86_pkg::CMD_CMOVGE) begin
      if (bad_a || bad_b) st = y86_pkg::ST_ERR;
      else begin
        if (test_cond(3'(cmd - y86_pkg::CMD_CMOVE))) regs[rb] = regs[ra];
        npc = pc_q + 2;
      end
    end else if (cmd >= y86_pkg::CMD_ADD && cmd <= y86_pkg::CMD_XOR) begin
      if (bad_a || bad_b) st = y86_pkg::ST_ERR;
      else begin
        va = regs[ra];
        vb = regs[rb];
        npc = pc_q + 2;
        if ((cmd == y86_pkg::CMD_MOD || cmd == y86_pkg::CMD_DIV) && va == 0) begin
          // Divide by zero fails; mod by zero only fails when both are zero.
          if (cmd == y86_pkg::CMD_DIV) st = y86_pkg::ST_ERR;
          else if (vb == 0) begin
            flags_q = 2'b01;
            st = y86_pkg::ST_ERR;
          end
        end else begin
          case (cmd)
            y86_pkg::CMD_ADD: t = vb + va;
            y86_pkg::CMD_SUB: t = vb - va;
            y86_pkg::CMD_MUL: t = vb * va;
            y86_pkg::CMD_MOD: begin divmod(vb, va, q, r); t = r; end
            y86_pkg::CMD_DIV: begin divmod(vb, va, q, r); t = q; end
            y86_pkg::CMD_AND: t = vb & va;
            default: t = vb ^ va;
          endcase
          regs[rb] = t;
          set_flags(t);
        end
      end
    end else begin
      case (cmd)
        y86_pkg::CMD_NOP: npc = pc_q + 1;
        y86_pkg::CMD_HALT: st = y86_pkg::ST_HALT;
        y86_pkg::CMD_RRMOV: begin
          if (bad_a || bad_b) st = y86_pkg::ST_ERR;
          else begin regs[rb] = regs[ra]; npc = pc_q + 2; end
        end
        y86_pkg::CMD_IRMOV: begin
          if (bad_b) st = y86_pkg::ST_ERR;
          else begin regs[rb] = imm; npc = pc_q + 10; end
        end
        y86_pkg::CMD_RMMOV: begin
          if (bad_a || bad_b || !window_hit(regs[rb] + imm, offset)) st = y86_pkg::ST_ERR;
          else begin store_quad(offset, regs[ra]); npc = pc_q + 10; end
        end
        y86_pkg::CMD_MRMOV: begin
          if (bad_a || bad_b || !window_hit(regs[rb] + imm, offset)) st = y86_pkg::ST_ERR;
          else begin regs[ra] = load_quad(offset); npc = pc_q + 10; end
        end
        y86_pkg::CMD_PUSH: begin
          if (bad_a || rsp < 8 || !window_hit(rsp - 8, offset)) st = y86_pkg::ST_ERR;
          else begin
            store_quad(offset, regs[ra]);
            regs[y86_pkg::StackReg] = rsp - 8;
            npc = pc_q + 2;
          end
        end
        y86_pkg::CMD_POP: begin
          if (bad_a || !window_hit(rsp, offset)) st = y86_pkg::ST_ERR;
          else begin
            t = load_quad(offset);
            regs[y86_pkg::StackReg] = rsp + 8;
            regs[ra] = t;
            npc = pc_q + 2;
          end
        end
        y86_pkg::CMD_CALL: begin
          if (rsp == 0 || !window_hit(rsp - 8, offset)) st = y86_pkg::ST_ERR;
          else begin
            store_quad(offset, pc_q + 9);
            regs[y86_pkg::StackReg] = rsp - 8;
            npc = imm;
          end
        end
        y86_pkg::CMD_RET: begin
          if (!window_hit(rsp, offset)) st = y86_pkg::ST_ERR;
          else begin
            npc = load_quad(offset);
            regs[y86_pkg::StackReg] = rsp + 8;
          end
        end
        y86_pkg::CMD_JMP: npc = imm;
        default: st = y86_pkg::ST_ERR;
      endcase
    end
    if (st == y86_pkg::ST_OK) pc_q = npc;
    expected_results[exp_wr % ExpDepth] = {4'd0, flags_q, pc_q, st};
    exp_wr = exp_wr + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [71:0] exp_word;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) regs[i] = '0;
      for (int i = 0; i < y86_pkg::MemBytes; i++) mem[i] = '0;
      pc_q = '0;
      flags_q = '0;
      base_q = '0;
      valid_q = 11'd1024;
      exp_wr = 0;
      exp_rd = 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == y86_pkg::CfgBase) base_q = cfg_wdata_i;
        else valid_q = cfg_wdata_i[10:0];
      end
      if (s_axis_tvalid && s_axis_tready) execute_instruction(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_wr == exp_rd) begin
          if (mismatch_count_o < 10)
            $display("unexpected result %h", m_axis_tdata);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_word = expected_results[exp_rd % ExpDepth];
          exp_rd = exp_rd + 1;
          if (exp_word[1:0] !== m_axis_tdata[1:0] || exp_word[65:2] !== m_axis_tdata[65:2]
              || exp_word[67:66] !== m_axis_tdata[67:66] || m_axis_tdata[71:68] !== 4'd0) begin
            if (mismatch_count_o < 10)
              $display("mismatch: expected st=%0d pc=%h fl=%0d, got st=%0d pc=%h fl=%0d",
                       exp_word[1:0], exp_word[65:2], exp_word[67:66],
                       m_axis_tdata[1:0], m_axis_tdata[65:2], m_axis_tdata[67:66]);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_count_o = exp_wr - exp_rd;

endmodule

// File: tb/sv/testbench.sv
// Top of the Y86 execute unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_wdata_i;
  int          mismatch_count;
  int          pending_count;
  // Percent of cycles in which the sender and the receiver hold back.
  int          send_idle_pct;
  int          recv_idle_pct;

  y86_instruction_execute_unit u_top (.*);

  y86_result_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random, at the current rate, independent of stimulus.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hard limit: the slowest legal run is far shorter than this.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Sends one request, with random idle cycles in front, and waits for acceptance.
  // The valid line stays high afterwards; the next request's idle cycles or drain_results drop it.
  task automatic send_request(y86_pkg::cmd_e cmd, logic [3:0] ra, logic [3:0] rb,
                              logic [63:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'd0, imm, rb, ra, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Waits until every result has come back, plus a margin for the block to settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_config(logic idx, logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_quad();
    return {$urandom, $urandom};
  endfunction

  // Values that stress arithmetic: extremes and small values near zero mixed with fully random patterns.
  function automatic logic [63:0] edgy_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return 64'h8000_0000_0000_0000;
      2: return '1;
      3: return 64'(int'($urandom_range(20)) - 10);
      4: return 64'h7fff_ffff_ffff_ffff;
      default: return random_quad();
    endcase
  endfunction

  // One random request. Most requests stay inside the window so memory, stack
  // and arithmetic paths are exercised deeply; the rest is noise.
  task automatic random_request();
    y86_pkg::cmd_e cmd;
    logic [3:0]    ra, rb;
    logic [63:0]   imm;
    int            pick;
    pick = $urandom_range(99);
    ra = ($urandom_range(19) == 0) ? y86_pkg::BadReg : 4'($urandom_range(14));
    rb = ($urandom_range(19) == 0) ? y86_pkg::BadReg : 4'($urandom_range(14));
    imm = random_quad();
    if (pick < 10) begin
      // Load a register with a stress value or a pointer near the window.
      cmd = y86_pkg::CMD_IRMOV;
      imm = ($urandom_range(1)) ? edgy_value() : 64'($urandom_range(1023));
      if (rb == y86_pkg::StackReg || $urandom_range(3) == 0) begin
        rb = y86_pkg::StackReg;
        imm = 64'($urandom_range(1040)) + (($urandom_range(3) == 0) ? random_quad() : 0);
      end
    end else if (pick < 40) begin
      cmd = y86_pkg::cmd_e'($urandom_range(y86_pkg::CMD_ADD, y86_pkg::CMD_XOR));
    end else if (pick < 55) begin
      cmd = y86_pkg::cmd_e'($urandom_range(y86_pkg::CMD_CMOVE, y86_pkg::CMD_CMOVGE));
    end else if (pick < 75) begin
      cmd = y86_pkg::cmd_e'($urandom_range(y86_pkg::CMD_RMMOV, y86_pkg::CMD_RET));
      imm = ($urandom_range(7) == 0) ? random_quad() : 64'(int'($urandom_range(1040)) - 16);
    end else if (pick < 90) begin
      cmd = y86_pkg::cmd_e'($urandom_range(y86_pkg::CMD_JMP, y86_pkg::CMD_JGE));
    end else begin
      cmd = y86_pkg::cmd_e'($urandom_range(31));
    end
    send_request(cmd, ra, rb, imm);
  endtask

  initial begin
    y86_pkg::cmd_e c;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = y86_pkg::CfgBase;
    cfg_wdata_i = '0;
    send_idle_pct = 20;
    recv_idle_pct = 82;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes, register 15, memory window edges, stack, and
    // the divide and mod by zero corner cases.
    send_request(y86_pkg::CMD_NOP, 4'd0, 4'd0, '0);
    send_request(y86_pkg::CMD_IRMOV, 4'd0, 4'd1, 64'h8000_0000_0000_0000);
    send_request(y86_pkg::CMD_IRMOV, 4'd0, 4'd2, '1);
    send_request(y86_pkg::CMD_DIV, 4'd2, 4'd1, '0);       // most negative / -1 wraps
    send_request(y86_pkg::CMD_MOD, 4'd2, 4'd1, '0);
    send_request(y86_pkg::CMD_MOD, 4'd0, 4'd2, '0);       // mod by zero, dividend nonzero
    send_request(y86_pkg::CMD_MOD, 4'd0, 4'd0, '0);       // mod by zero, both zero
    send_request(y86_pkg::CMD_DIV, 4'd0, 4'd2, '0);       // divide by zero
    send_request(y86_pkg::CMD_IRMOV, 4'd0, y86_pkg::BadReg, '1);
    send_request(y86_pkg::CMD_ADD, y86_pkg::BadReg, 4'd1, '0);
    send_request(y86_pkg::CMD_PUSH, 4'd2, 4'd0, '0);      // rsp is zero
    send_request(y86_pkg::CMD_CALL, 4'd0, 4'd0, 64'h40);  // rsp is zero
    send_request(y86_pkg::CMD_IRMOV, 4'd0, y86_pkg::StackReg, 64'd1024);
    send_request(y86_pkg::CMD_PUSH, y86_pkg::StackReg, 4'd0, '0);  // pushes the old rsp
    send_request(y86_pkg::CMD_CALL, 4'd0, 4'd0, 64'h40);
    send_request(y86_pkg::CMD_RET, 4'd0, 4'd0, '0);
    send_request(y86_pkg::CMD_POP, y86_pkg::StackReg, 4'd0, '0);   // pop into rsp
    send_request(y86_pkg::CMD_RMMOV, 4'd2, 4'd0, 64'd1016);
    send_request(y86_pkg::CMD_MRMOV, 4'd3, 4'd0, 64'd1017); // one past the window
    send_request(y86_pkg::CMD_MRMOV, 4'd3, 4'd0, 64'd1016);
    send_request(y86_pkg::CMD_JLE, 4'd0, 4'd0, 64'h123);
    send_request(y86_pkg::CMD_CMOVG, 4'd2, 4'd3, '0);
    send_request(y86_pkg::CMD_HALT, 4'd0, 4'd0, '0);
    send_request(y86_pkg::CMD_BAD1, 4'd0, 4'd0, '0);
    for (int i = 0; i < 30; i++) begin
      c = y86_pkg::cmd_e'(i);
      send_request(c, 4'd1, 4'd2, 64'd8);
    end

    // Sender pauses until every expected result is back, then settings change.
    drain_results();
    write_config(y86_pkg::CfgBase, '1);
    write_config(y86_pkg::CfgValid, 64'd0);
    for (int i = 0; i < 20; i++) random_request();
    drain_results();
    write_config(y86_pkg::CfgBase, 64'h100);
    write_config(y86_pkg::CfgValid, 64'd8);
    for (int i = 0; i < 30; i++) random_request();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 20 : 0;
      drain_results();
      write_config(y86_pkg::CfgBase, (phase == 1) ? 64'($urandom_range(64)) : 64'd0);
      write_config(y86_pkg::CfgValid,
                   (phase == 2) ? 64'd1024 : 64'($urandom_range(8, 2047)));
      for (int i = 0; i < 220; i++) random_request();
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
